[sv/biup_pkg.sv]
// Package for the bicubic image upscaler: field widths, command and register
// codes, clamp limits and the per-item sideband type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package biup_pkg;

  localparam int COORD_W  = 10;
  localparam int SAMPLE_W = 16;
  localparam int PIXEL_W  = 12;
  localparam int DIM_W    = 5;
  localparam int TDIM_W   = 11;
  localparam int XI_W     = DIM_W;
  localparam int PX_W     = COORD_W + DIM_W;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  localparam int PIX_MAX  = 4000;
  localparam int PIX_MIN  = 1;
  localparam int GUARD_W  = 26;

  localparam logic CMD_STORE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_DST_W = 2'd2;
  localparam logic [1:0] REG_DST_H = 2'd3;

  localparam logic [DIM_W-1:0]  SRC_W_RST = 5'd8;
  localparam logic [DIM_W-1:0]  SRC_H_RST = 5'd8;
  localparam logic [TDIM_W-1:0] DST_W_RST = 11'd64;
  localparam logic [TDIM_W-1:0] DST_H_RST = 11'd64;

  typedef struct packed {
    logic                cmd;
    logic                err;
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [SAMPLE_W-1:0] smp;
  } side_t;

endpackage
`default_nettype wire

[sv/biup_in_if.sv]
// Input item channel of the upscaler: valid/ready plus command, coordinates
// and sample. Depends on biup_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface biup_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [biup_pkg::COORD_W-1:0]  coord_x;
  logic [biup_pkg::COORD_W-1:0]  coord_y;
  logic [biup_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, cmd, coord_x, coord_y, sample_in, input ready);
  modport sink   (input valid, cmd, coord_x, coord_y, sample_in, output ready);
endinterface
`default_nettype wire

[sv/biup_out_if.sv]
// Result item channel of the upscaler: valid/ready plus pixel and range flag.
// Depends on biup_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface biup_out_if;
  logic                         valid;
  logic                         ready;
  logic [biup_pkg::PIXEL_W-1:0] pixel_out;
  logic                         range_error;

  modport source (output valid, pixel_out, range_error, input ready);
  modport sink   (input valid, pixel_out, range_error, output ready);
endinterface
`default_nettype wire

[sv/biup_div.sv]
// Pipelined restoring divider, one quotient bit per stage. The initial
// partial remainder must be below the divisor. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module biup_div #(
  parameter int DW = 11,
  parameter int QW = 21
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] num_hi,
  input  wire logic [QW-1:0] num_lo,
  input  wire logic [DW-1:0] den,
  output logic      [QW-1:0] quo
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] lo_r  [QW];
  logic [QW-1:0] q_r   [QW];

  logic [DW-1:0] rem_nxt [QW];
  logic [QW-1:0] lo_nxt  [QW];
  logic [QW-1:0] q_nxt   [QW];

  always_comb begin
    logic [DW:0]   trial;
    logic [DW-1:0] rin;
    logic [QW-1:0] lin;
    logic [QW-1:0] qin;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rin = num_hi;
        lin = num_lo;
        qin = '0;
      end else begin
        rin = rem_r[k-1];
        lin = lo_r[k-1];
        qin = q_r[k-1];
      end
      trial = {rin, lin[QW-1]};
      lo_nxt[k] = {lin[QW-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_nxt[k] = DW'(trial - {1'b0, den});
        q_nxt[k]   = {qin[QW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[DW-1:0];
        q_nxt[k]   = {qin[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k] <= rem_nxt[k];
        lo_r[k]  <= lo_nxt[k];
        q_r[k]   <= q_nxt[k];
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule
`default_nettype wire

[sv/biup_spline.sv]
// Five-stage Catmull-Rom spline on signed fixed-point taps, three multipliers,
// at most one per stage. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module biup_spline #(
  parameter int W = 42,
  parameter int F = 16
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [W-1:0] tap_a,
  input  wire logic signed [W-1:0] tap_b,
  input  wire logic signed [W-1:0] tap_c,
  input  wire logic signed [W-1:0] tap_d,
  input  wire logic        [F-1:0] frac,
  output logic signed      [W-1:0] y
);

  localparam int PW = W + F + 1;

  logic signed [W-1:0]  a2_r, b2_r1, c2_r1, b_r1;
  logic        [F-1:0]  t_r1;
  logic signed [PW-1:0] p1_r;
  logic signed [W-1:0]  b2_r2, c2_r2, b_r2;
  logic        [F-1:0]  t_r2;
  logic signed [PW-1:0] p2_r;
  logic signed [W-1:0]  c2_r3, b_r3;
  logic        [F-1:0]  t_r3;
  logic signed [PW-1:0] p3_r;
  logic signed [W-1:0]  b_r4;
  logic signed [W-1:0]  y_r;

  logic signed [W-1:0]  bc_diff, v1, v2;
  logic signed [F:0]    t1s, t2s, t3s;

  assign bc_diff = tap_b - tap_c;
  assign t1s = $signed({1'b0, t_r1});
  assign t2s = $signed({1'b0, t_r2});
  assign t3s = $signed({1'b0, t_r3});
  assign v1  = W'(p1_r >>> F) + b2_r2;
  assign v2  = W'(p2_r >>> F) + c2_r3;

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r  <= (tap_d - tap_a) + (bc_diff <<< 1) + bc_diff;
      b2_r1 <= (tap_a <<< 1) - (tap_b <<< 2) - tap_b + (tap_c <<< 2) - tap_d;
      c2_r1 <= tap_c - tap_a;
      b_r1  <= tap_b;
      t_r1  <= frac;

      p1_r  <= a2_r * t1s;
      b2_r2 <= b2_r1;
      c2_r2 <= c2_r1;
      b_r2  <= b_r1;
      t_r2  <= t_r1;

      p2_r  <= v1 * t2s;
      c2_r3 <= c2_r2;
      b_r3  <= b_r2;
      t_r3  <= t_r2;

      p3_r  <= v2 * t3s;
      b_r4  <= b_r3;

      y_r   <= W'(p3_r >>> (F + 1)) + b_r4;
    end
  end

  assign y = y_r;

endmodule
`default_nettype wire

[sv/bicubic_image_upscaler_top.sv]
// Bicubic depth-image upscaler, top level.
// Depends on biup_pkg, biup_in_if, biup_out_if, biup_div, biup_spline.
//
// Usage:
//   in_if  : items with cmd, coord_x, coord_y, sample_in. A store item
//            (cmd 0) writes one in-frame pixel of the source frame and gives no
//            result. A compute item (cmd 1) gives one result item.
//   out_if : pixel_out (1..4000, or 0 with range_error set).
//   APB    : source_width at 0x0, source_height at 0x4, target_width at
//            0x8, target_height at 0xC. Write only while the pipe is empty.
// Throughput: one item per cycle, fully pipelined, while the receiver does not stall.
// From acceptance to result valid, an item passes the pipelined divider stages
//   (one per quotient bit) and the column and row five-stage spline units.
// The source frame sits in 16 banks (column and row mod 4), so all 16 taps
//   of a neighbourhood are read in the same cycle. It holds garbage until written.
// Reset clears all valid bits and loads the default register values; no
//   clearing pass is needed.
// When the receiver stalls, the whole pipe freezes; in_if.ready drops
//   while a result waits and out_if.ready is low.
`timescale 1ns / 1ps
`default_nettype none
module bicubic_image_upscaler_top #(
  parameter int MAX_SOURCE_WIDTH  = 16,
  parameter int MAX_SOURCE_HEIGHT = 16,
  parameter int FRACTION_BITS     = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  biup_in_if.sink                              in_if,
  biup_out_if.source                           out_if,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [biup_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [biup_pkg::PDATA_W-1:0]    pwdata,
  output logic      [biup_pkg::PDATA_W-1:0]    prdata,
  output logic                                 pready
);
  import biup_pkg::*;

  localparam int F   = FRACTION_BITS;
  localparam int QW  = XI_W + F;
  localparam int W   = F + GUARD_W;
  localparam int BX  = (MAX_SOURCE_WIDTH + 3) / 4;
  localparam int BY  = (MAX_SOURCE_HEIGHT + 3) / 4;
  localparam int BD  = BX * BY;
  localparam int AW  = (BD > 1) ? $clog2(BD) : 1;
  localparam int IA  = QW + 2;
  localparam int IR  = QW + 3;
  localparam int IC  = QW + 8;
  localparam int IO  = QW + 13;
  localparam int NS  = QW + 14;

  localparam logic signed [W-1:0] ONE_Q = W'(1) <<< F;
  localparam logic signed [W-1:0] MAX_Q = W'(PIX_MAX) <<< F;

  // configuration
  logic [DIM_W-1:0]  src_w_r, src_h_r;
  logic [TDIM_W-1:0] dst_w_r, dst_h_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= SRC_W_RST;
      src_h_r <= SRC_H_RST;
      dst_w_r <= DST_W_RST;
      dst_h_r <= DST_H_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SRC_W: src_w_r <= pwdata[DIM_W-1:0];
        REG_SRC_H: src_h_r <= pwdata[DIM_W-1:0];
        REG_DST_W: dst_w_r <= pwdata[TDIM_W-1:0];
        REG_DST_H: dst_h_r <= pwdata[TDIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SRC_W: prdata = PDATA_W'(src_w_r);
      REG_SRC_H: prdata = PDATA_W'(src_h_r);
      REG_DST_W: prdata = PDATA_W'(dst_w_r);
      REG_DST_H: prdata = PDATA_W'(dst_h_r);
      default:   prdata = '0;
    endcase
  end

  logic [DIM_W-1:0] sw, sh;

  always_comb begin
    sw = src_w_r;
    if (src_w_r == '0) sw = DIM_W'(1);
    else if (32'(src_w_r) > MAX_SOURCE_WIDTH) sw = DIM_W'(MAX_SOURCE_WIDTH);
    sh = src_h_r;
    if (src_h_r == '0) sh = DIM_W'(1);
    else if (32'(src_h_r) > MAX_SOURCE_HEIGHT) sh = DIM_W'(MAX_SOURCE_HEIGHT);
  end

  // pipe control
  logic          en;
  logic          out_vld_r;
  logic [NS-1:0] vld_r;
  side_t         side_r [NS];
  logic [F-1:0]  tx_r   [NS];
  logic [F-1:0]  ty_r   [NS];

  assign en          = !out_vld_r || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_if.valid};
    end
  end

  // stage 1: scale products and range check
  logic [PX_W-1:0] px_r, py_r;
  logic [QW-1:0]   qx, qy;
  logic            err0;

  assign err0 = ({1'b0, side_r[0].cx} >= dst_w_r) || ({1'b0, side_r[0].cy} >= dst_h_r);

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0].cmd <= in_if.cmd;
      side_r[0].err <= 1'b0;
      side_r[0].cx  <= in_if.coord_x;
      side_r[0].cy  <= in_if.coord_y;
      side_r[0].smp <= in_if.sample_in;
      tx_r[0]       <= '0;
      ty_r[0]       <= '0;
      for (int k = 1; k < NS; k++) begin
        if (k == 1) begin
          side_r[k] <= {side_r[0].cmd, err0, side_r[0].cx, side_r[0].cy, side_r[0].smp};
        end else begin
          side_r[k] <= side_r[k-1];
        end
        if (k == IA) begin
          tx_r[k] <= qx[F-1:0];
          ty_r[k] <= qy[F-1:0];
        end else begin
          tx_r[k] <= tx_r[k-1];
          ty_r[k] <= ty_r[k-1];
        end
      end
      px_r <= PX_W'(side_r[0].cx) * PX_W'(sw);
      py_r <= PX_W'(side_r[0].cy) * PX_W'(sh);
    end
  end

  // source position: (c * s << F) / target
  biup_div #(.DW(TDIM_W), .QW(QW)) u_div_x (
    .clk    (clk),
    .en     (en),
    .num_hi (TDIM_W'(px_r >> XI_W)),
    .num_lo ({px_r[XI_W-1:0], {F{1'b0}}}),
    .den    (dst_w_r),
    .quo    (qx)
  );

  biup_div #(.DW(TDIM_W), .QW(QW)) u_div_y (
    .clk    (clk),
    .en     (en),
    .num_hi (TDIM_W'(py_r >> XI_W)),
    .num_lo ({py_r[XI_W-1:0], {F{1'b0}}}),
    .den    (dst_h_r),
    .quo    (qy)
  );

  // neighbourhood indices and bank addresses
  logic [DIM_W-1:0]  cm [4];
  logic [DIM_W-1:0]  rn [4];
  logic [DIM_W-1:0]  selx [4];
  logic [DIM_W-1:0]  sely [4];
  logic [AW-1:0]     rd_addr_nxt [16];
  logic [AW-1:0]     rd_addr_r [16];
  logic [1:0]        cl_r [4], rl_r [4], cl2_r [4], rl2_r [4];
  logic              wr_ok_r;
  logic [3:0]        wr_bank_r;
  logic [AW-1:0]     wr_addr_r;
  logic [SAMPLE_W-1:0] wr_data_r;
  logic              st_in;

  always_comb begin
    logic signed [DIM_W+1:0] pos;
    logic [XI_W-1:0]         xi, yi;
    xi = qx[QW-1:F];
    yi = qy[QW-1:F];
    for (int m = 0; m < 4; m++) begin
      pos = $signed({2'b00, xi}) + (DIM_W+2)'(m) - (DIM_W+2)'(1);
      if (pos < 0) cm[m] = '0;
      else if (pos >= $signed({2'b00, sw})) cm[m] = sw - DIM_W'(1);
      else cm[m] = pos[DIM_W-1:0];
      pos = $signed({2'b00, yi}) + (DIM_W+2)'(m) - (DIM_W+2)'(1);
      if (pos < 0) rn[m] = '0;
      else if (pos >= $signed({2'b00, sh})) rn[m] = sh - DIM_W'(1);
      else rn[m] = pos[DIM_W-1:0];
    end
    for (int b = 0; b < 4; b++) begin
      selx[b] = '0;
      sely[b] = '0;
      for (int m = 0; m < 4; m++) begin
        if (cm[m][1:0] == 2'(b)) selx[b] = cm[m];
        if (rn[m][1:0] == 2'(b)) sely[b] = rn[m];
      end
    end
    for (int by = 0; by < 4; by++) begin
      for (int bx = 0; bx < 4; bx++) begin
        rd_addr_nxt[by*4+bx] = AW'((int'(sely[by]) >> 2) * BX + (int'(selx[bx]) >> 2));
      end
    end
  end

  assign st_in = (32'(side_r[IA-1].cx) < MAX_SOURCE_WIDTH) &&
                 (32'(side_r[IA-1].cy) < MAX_SOURCE_HEIGHT);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 16; k++) rd_addr_r[k] <= rd_addr_nxt[k];
      for (int m = 0; m < 4; m++) begin
        cl_r[m]  <= cm[m][1:0];
        rl_r[m]  <= rn[m][1:0];
        cl2_r[m] <= cl_r[m];
        rl2_r[m] <= rl_r[m];
      end
      wr_ok_r   <= (side_r[IA-1].cmd == CMD_STORE) && st_in;
      wr_bank_r <= {side_r[IA-1].cy[1:0], side_r[IA-1].cx[1:0]};
      wr_addr_r <= AW'((32'(side_r[IA-1].cy) >> 2) * BX + (32'(side_r[IA-1].cx) >> 2));
      wr_data_r <= side_r[IA-1].smp;
    end
  end

  // banked source frame
  logic [SAMPLE_W-1:0] rd_r [16];

  for (genvar b = 0; b < 16; b++) begin : g_bank
    logic [SAMPLE_W-1:0] mem [BD];
    always_ff @(posedge clk) begin
      if (en) begin
        if (vld_r[IA] && wr_ok_r && (wr_bank_r == 4'(b))) begin
          mem[wr_addr_r] <= wr_data_r;
        end
        rd_r[b] <= mem[rd_addr_r[b]];
      end
    end
  end

  // column splines along y, then one along x
  logic signed [W-1:0] tap [4][4];
  logic signed [W-1:0] col [4];
  logic signed [W-1:0] vrow;

  always_comb begin
    for (int m = 0; m < 4; m++) begin
      for (int n = 0; n < 4; n++) begin
        tap[m][n] = $signed({{(W-SAMPLE_W-F){1'b0}}, rd_r[{rl2_r[n], cl2_r[m]}],
                             {F{1'b0}}});
      end
    end
  end

  for (genvar m = 0; m < 4; m++) begin : g_col
    biup_spline #(.W(W), .F(F)) u_col (
      .clk   (clk),
      .en    (en),
      .tap_a (tap[m][0]),
      .tap_b (tap[m][1]),
      .tap_c (tap[m][2]),
      .tap_d (tap[m][3]),
      .frac  (ty_r[IR]),
      .y     (col[m])
    );
  end

  biup_spline #(.W(W), .F(F)) u_row (
    .clk   (clk),
    .en    (en),
    .tap_a (col[0]),
    .tap_b (col[1]),
    .tap_c (col[2]),
    .tap_d (col[3]),
    .frac  (tx_r[IC]),
    .y     (vrow)
  );

  // clamp and output register
  logic [PIXEL_W-1:0] pix_nxt, pix_r;
  logic               err_r;

  always_comb begin
    if (side_r[IO].err) pix_nxt = '0;
    else if (vrow < ONE_Q) pix_nxt = PIXEL_W'(PIX_MIN);
    else if (vrow > MAX_Q) pix_nxt = PIXEL_W'(PIX_MAX);
    else pix_nxt = vrow[F +: PIXEL_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[IO] && (side_r[IO].cmd == CMD_COMPUTE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
      err_r <= side_r[IO].err;
    end
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.pixel_out   = pix_r;
  assign out_if.range_error = err_r;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && err_r |-> pix_r == '0)
    else $error("range error with nonzero pixel");

  a_pix_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !err_r |-> (pix_r >= PIXEL_W'(PIX_MIN)) && (pix_r <= PIXEL_W'(PIX_MAX)))
    else $error("pixel outside clamp range");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_if.ready |=> $stable(vld_r))
    else $error("pipe moved during stall");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_vld_r && (vld_r == '0))
    else $error("valid bits set after reset");
`endif

endmodule
`default_nettype wire

[dv/bicubic_image_upscaler_checker.sv]
// Scoreboard for the bicubic upscaler: tracks the source frame and registers,
// predicts each compute item's pixel and compares it with the result channel.
// Depends on biup_pkg, biup_in_if and biup_out_if.
`timescale 1ns / 1ps
module bicubic_image_upscaler_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  biup_in_if                               in_if,
  biup_out_if                              out_if,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [biup_pkg::PADDR_W-1:0]     paddr,
  input  logic [biup_pkg::PDATA_W-1:0]     pwdata,
  output int                               fail_count,
  output int                               pending
);
  import biup_pkg::*;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               err;
  } pixel_res_t;

  logic [SAMPLE_W-1:0] frame [256];
  logic [DIM_W-1:0]    src_w, src_h;
  logic [TDIM_W-1:0]   dst_w, dst_h;
  pixel_res_t          pixel_q [$];

  function automatic longint scale_frac(longint v, longint t);
    longint hi, lo;
    hi = v >>> 16;
    lo = v - hi * 65536;
    return hi * t + ((lo * t) >>> 16);
  endfunction

  function automatic longint catmull_rom(longint a, longint b, longint c, longint d,
                                         longint t);
    longint v;
    v = scale_frac(-a + 3 * b - 3 * c + d, t) + (2 * a - 5 * b + 4 * c - d);
    v = scale_frac(v, t) + (c - a);
    v = scale_frac(v, t);
    return (v >>> 1) + b;
  endfunction

  function automatic int clamp_idx(int v, int size);
    if (v < 0) return 0;
    if (v >= size) return size - 1;
    return v;
  endfunction

  function automatic pixel_res_t upscale_pixel(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
    pixel_res_t r;
    longint sw, sh, px, py, tx, ty, v;
    longint tap [4];
    longint col [4];
    int xi, yi, xs, ys;
    r = '0;
    if (cx >= dst_w || cy >= dst_h) begin
      r.err = 1'b1;
      return r;
    end
    sw = (src_w < 1) ? 1 : (src_w > 16) ? 16 : src_w;
    sh = (src_h < 1) ? 1 : (src_h > 16) ? 16 : src_h;
    px = longint'(cx) * sw;
    py = longint'(cy) * sh;
    xi = int'(px / dst_w);
    yi = int'(py / dst_h);
    tx = ((px % dst_w) << 16) / dst_w;
    ty = ((py % dst_h) << 16) / dst_h;
    for (int m = 0; m < 4; m++) begin
      xs = clamp_idx(xi + m - 1, int'(sw));
      for (int n = 0; n < 4; n++) begin
        ys = clamp_idx(yi + n - 1, int'(sh));
        tap[n] = longint'(frame[ys * 16 + xs]) * 65536;
      end
      col[m] = catmull_rom(tap[0], tap[1], tap[2], tap[3], ty);
    end
    v = catmull_rom(col[0], col[1], col[2], col[3], tx);
    if (v < 65536) r.pixel = PIXEL_W'(PIX_MIN);
    else if (v > longint'(PIX_MAX) * 65536) r.pixel = PIXEL_W'(PIX_MAX);
    else r.pixel = PIXEL_W'(v >>> 16);
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_res_t exp_res;
    if (!rst_n) begin
      src_w = SRC_W_RST;
      src_h = SRC_H_RST;
      dst_w = DST_W_RST;
      dst_h = DST_H_RST;
      pixel_q.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SRC_W: src_w = pwdata[DIM_W-1:0];
          REG_SRC_H: src_h = pwdata[DIM_W-1:0];
          REG_DST_W: dst_w = pwdata[TDIM_W-1:0];
          REG_DST_H: dst_h = pwdata[TDIM_W-1:0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        if (pixel_q.size() == 0) begin
          $error("result item with none expected");
          fail_count++;
        end else begin
          exp_res = pixel_q.pop_front();
          if (out_if.pixel_out !== exp_res.pixel) begin
            $error("pixel_out expected %0d actual %0d", exp_res.pixel, out_if.pixel_out);
            fail_count++;
          end
          if (out_if.range_error !== exp_res.err) begin
            $error("range_error expected %0d actual %0d", exp_res.err, out_if.range_error);
            fail_count++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        if (in_if.cmd == CMD_STORE) begin
          if (in_if.coord_x < 16 && in_if.coord_y < 16)
            frame[in_if.coord_y * 16 + in_if.coord_x] = in_if.sample_in;
        end else begin
          pixel_q.push_back(upscale_pixel(in_if.coord_x, in_if.coord_y));
        end
      end
    end
    pending = pixel_q.size();
  end
endmodule

[dv/bicubic_image_upscaler_top_tb.sv]
// Testbench top for the bicubic upscaler: clock, reset, APB register writes,
// store/compute stimulus and result-side stalls; verdict from the checker.
// Depends on biup_pkg, the channel interfaces, the DUT and the checker.
`timescale 1ns / 1ps
module bicubic_image_upscaler_top_tb;
  import biup_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  int fail_count, pending;
  bit long_hold_req = 0;
  bit no_idle = 0;
  int cur_tw = 64, cur_th = 64;

  biup_in_if  in_ch ();
  biup_out_if out_ch ();

  bicubic_image_upscaler_top dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bicubic_image_upscaler_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_STORE;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.sample_in = '0;
    out_ch.ready = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  // result side: random stalls per item, one long hold on request
  initial begin
    int k;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold_req = 0;
      end
      k = no_idle ? 0 : $urandom_range(0, 3);
      if (k > 0) begin
        out_ch.ready <= 1'b0;
        repeat (k) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_item(logic cmd, int x, int y, int s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.coord_x <= COORD_W'(x);
    in_ch.coord_y <= COORD_W'(y);
    in_ch.sample_in <= SAMPLE_W'(s);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] reg_idx, int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_geometry(int sw, int sh, int tw, int th);
    drain_pipe();
    apb_write(REG_SRC_W, sw);
    apb_write(REG_SRC_H, sh);
    apb_write(REG_DST_W, tw);
    apb_write(REG_DST_H, th);
    cur_tw = tw & 11'h7ff;
    cur_th = th & 11'h7ff;
  endtask

  task automatic random_items(int count);
    int x, y, hx, hy;
    for (int n = 0; n < count; n++) begin
      hx = (cur_tw > 1023) ? 1023 : cur_tw;
      hy = (cur_th > 1023) ? 1023 : cur_th;
      if ($urandom_range(0, 9) < 7) begin
        x = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, hx);
        y = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, hy);
        send_item(CMD_COMPUTE, x, y, $urandom_range(0, 65535));
      end else if ($urandom_range(0, 9) == 0) begin
        send_item(CMD_STORE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 65535));
      end else begin
        send_item(CMD_STORE, $urandom_range(0, 15), $urandom_range(0, 15),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 4200));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole source frame so no tap ever reads an unwritten entry
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++)
        send_item(CMD_STORE, c, r, $urandom_range(0, 4095));

    // directed: corners, range errors, off-frame stores, sample extremes
    send_item(CMD_COMPUTE, 0, 0, 0);
    send_item(CMD_COMPUTE, 63, 63, 0);
    send_item(CMD_COMPUTE, 64, 0, 0);
    send_item(CMD_COMPUTE, 0, 64, 0);
    send_item(CMD_COMPUTE, 1023, 1023, 16'hffff);
    send_item(CMD_STORE, 16, 0, 16'hffff);
    send_item(CMD_STORE, 0, 16, 16'hffff);
    send_item(CMD_STORE, 1023, 1023, 16'hffff);
    send_item(CMD_COMPUTE, 0, 0, 0);
    send_item(CMD_STORE, 3, 3, 16'hffff);
    send_item(CMD_STORE, 4, 3, 0);
    send_item(CMD_COMPUTE, 27, 27, 0);
    send_item(CMD_COMPUTE, 30, 26, 0);
    send_item(CMD_COMPUTE, 34, 28, 0);
    send_item(CMD_STORE, 3, 3, 100);
    send_item(CMD_STORE, 4, 3, 200);
    send_item(CMD_COMPUTE, 31, 24, 0);

    random_items(50);

    set_geometry(1, 1, 1, 1);
    send_item(CMD_COMPUTE, 0, 0, 0);
    send_item(CMD_COMPUTE, 1, 0, 0);
    random_items(150);

    set_geometry(16, 16, 1024, 1024);
    send_item(CMD_COMPUTE, 1023, 1023, 0);
    send_item(CMD_COMPUTE, 0, 1023, 0);
    no_idle = 1;
    random_items(150);
    no_idle = 0;
    long_hold_req = 1;
    random_items(150);
    drain_pipe();
    random_items(100);

    set_geometry(0, 0, 0, 0);
    random_items(80);

    set_geometry(31, 31, 2047, 2047);
    random_items(150);

    set_geometry(3, 5, 7, 11);
    random_items(200);

    set_geometry(16, 2, 5, 1000);
    random_items(150);

    set_geometry($urandom_range(1, 16), $urandom_range(1, 16),
                 $urandom_range(1, 1024), $urandom_range(1, 1024));
    random_items(200);

    set_geometry(8, 8, 64, 64);
    random_items(150);

    drain_pipe();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[filelist.f]
sv/biup_pkg.sv
sv/biup_in_if.sv
sv/biup_out_if.sv
sv/biup_div.sv
sv/biup_spline.sv
sv/bicubic_image_upscaler_top.sv
dv/bicubic_image_upscaler_checker.sv
dv/bicubic_image_upscaler_top_tb.sv
